// ===== hw/rtl/cppd_pkg.sv =====
// ============================================================================
// cppd_pkg: close particle pair detector shared definitions
// Payload structs, store entry layout, status struct and fixed widths.
// ============================================================================
package cppd_pkg;

    localparam int MAX_PARTICLES      = 1024;
    localparam int MAX_REPORTED_PAIRS = 63;
    localparam int COORD_WIDTH        = 20;
    localparam int IDX_WIDTH          = 10;
    localparam int THRESH_WIDTH       = 44;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 44'd10486;

    // differences of 2^22 or more can never be close
    localparam int MAG_WIDTH = 22;
    localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH = SQ_WIDTH + 2;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        action_t action;
        logic    is_ghost;
        coord_t  pos_x;
        coord_t  pos_y;
        coord_t  pos_z;
    } in_item_t;

    typedef struct packed {
        logic                 is_pair;
        logic [IDX_WIDTH-1:0] earlier_index;
        logic [IDX_WIDTH-1:0] new_index;
        logic [IDX_WIDTH-1:0] close_count;
        logic                 truncated;
        logic                 set_full;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic   ghost;
        coord_t x;
        coord_t y;
        coord_t z;
    } store_entry_t;

    // distance pipeline status toward the sequencer
    typedef struct packed {
        logic valid;
        logic close;
        logic busy;
    } dist_status_t;

endpackage

// ===== hw/rtl/cppd_ram.sv =====
// ============================================================================
// cppd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while idle.
// ============================================================================
module cppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/cppd_dist.sv =====
// ============================================================================
// cppd_dist: squared distance compare pipeline
// Abs differences, then squares, then sum and threshold compare.
// ============================================================================
module cppd_dist
    import cppd_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ADDR_W-1:0]       in_idx,
    input  store_entry_t            entry,
    input  coord_t                  pos_x,
    input  coord_t                  pos_y,
    input  coord_t                  pos_z,
    input  logic [THRESH_WIDTH-1:0] thresh,
    output dist_status_t            status,
    output logic [ADDR_W-1:0]       out_idx
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int EXT_W  = (DIFF_W > MAG_WIDTH + 1) ? DIFF_W : MAG_WIDTH + 1;

    // {far, magnitude}
    function automatic logic [MAG_WIDTH:0] abs_mag(coord_t a, coord_t b);
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        logic [EXT_W-1:0]         e;
        d = DIFF_W'(a) - DIFF_W'(b);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        e = EXT_W'(m);
        return {|e[EXT_W-1:MAG_WIDTH], e[MAG_WIDTH-1:0]};
    endfunction

    logic [MAG_WIDTH:0] mx, my, mz;

    logic                 va_reg, va_next;
    logic                 skipa_reg, skipa_next;
    logic [ADDR_W-1:0]    idxa_reg;
    logic [MAG_WIDTH-1:0] magx_reg, magy_reg, magz_reg;

    logic                 vb_reg, vb_next;
    logic                 skipb_reg;
    logic [ADDR_W-1:0]    idxb_reg;
    logic [SQ_WIDTH-1:0]  sqx_reg, sqy_reg, sqz_reg;

    logic [SUM_WIDTH-1:0] sum;

    assign mx = abs_mag(pos_x, entry.x);
    assign my = abs_mag(pos_y, entry.y);
    assign mz = abs_mag(pos_z, entry.z);

    always_comb
    begin
        va_next    = en ? in_valid : va_reg;
        vb_next    = en ? va_reg : vb_reg;
        skipa_next = entry.ghost | mx[MAG_WIDTH] | my[MAG_WIDTH] | mz[MAG_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skipa_reg <= skipa_next;
            idxa_reg  <= in_idx;
            magx_reg  <= mx[MAG_WIDTH-1:0];
            magy_reg  <= my[MAG_WIDTH-1:0];
            magz_reg  <= mz[MAG_WIDTH-1:0];
            skipb_reg <= skipa_reg;
            idxb_reg  <= idxa_reg;
            sqx_reg   <= magx_reg * magx_reg;
            sqy_reg   <= magy_reg * magy_reg;
            sqz_reg   <= magz_reg * magz_reg;
        end
    end

    assign sum = SUM_WIDTH'(sqx_reg) + SUM_WIDTH'(sqy_reg) + SUM_WIDTH'(sqz_reg);

    assign status.valid = vb_reg;
    assign status.close = vb_reg & ~skipb_reg & (sum < SUM_WIDTH'(thresh));
    assign status.busy  = va_reg | vb_reg;
    assign out_idx      = idxb_reg;

endmodule

// ===== hw/rtl/close_particle_pair_detector_core.sv =====
// ============================================================================
// close_particle_pair_detector_core: brute-force close pair detection
// Stores particles in a RAM and scans every earlier one for each new item.
// ============================================================================
// Usage:
//   in channel  (in_valid/in_stall/in_item): add or clear beats. A beat is
//     taken only while the core is idle; in_stall is high during a scan.
//   out channel (out_valid/out_stall/out_item): zero to MAX_REPORTED_PAIRS
//     pair beats, in ascending earlier index, then one summary beat with
//     last set. A clear produces no beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes close_distance_sq;
//     cfg_ready is always high. Write only while the core is idle.
// Timing:
//   The scan issues one particle RAM read per cycle for each earlier stored
//   particle while out_stall does not hold the pipeline; a ghost, a rejected
//   add or a clear issues no read at all. The RAM read port sets
//   the rate. The summary is loaded into the output register as the core
//   returns to idle, so the next beat is taken while it still waits.
// Stall: a high out_stall while a beat waits in the output register freezes
//   the RAM read and the compare pipeline; nothing is lost.
// Reset: particle count clears, threshold returns to 10486. The particle
//   RAM is not cleared; only entries below the count are ever read.
// ============================================================================
module close_particle_pair_detector_core
    import cppd_pkg::*;
#(
    parameter int MAX_PARTICLES      = cppd_pkg::MAX_PARTICLES,
    parameter int MAX_REPORTED_PAIRS = cppd_pkg::MAX_REPORTED_PAIRS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_item_t               out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [THRESH_WIDTH-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [THRESH_WIDTH-1:0] thresh_reg, thresh_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        found_reg, found_next;
    logic [ADDR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    out_valid_reg, out_valid_next;

    // per-item context, loaded on accept
    logic [ADDR_W-1:0] idx_reg;
    logic              skip_reg;
    logic              full_reg;
    coord_t            x_reg, y_reg, z_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    out_item_t         out_item_reg, out_item_next;

    logic              in_acc;
    logic              is_full;
    logic              adv;
    logic              issue;
    logic              scan_end;
    logic              pair_hit;
    logic              pair_report;
    logic              ram_wr;
    store_entry_t      wr_entry;
    store_entry_t      rd_entry;
    dist_status_t      dist_st;
    logic [ADDR_W-1:0] dist_idx;

    // pipeline moves whenever the output slot is free or being drained
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign is_full  = (count_reg >= CNT_W'(MAX_PARTICLES));
    assign ram_wr   = in_acc && (in_item.action == ACT_ADD) && !is_full;

    assign issue    = (state_reg == ST_SCAN) && !skip_reg && (rd_ptr_reg < idx_reg) && adv;
    assign scan_end = (state_reg == ST_SCAN) && (skip_reg || rd_ptr_reg == idx_reg)
                      && !rd_valid_reg && !dist_st.busy;
    assign pair_hit    = adv && dist_st.close;
    assign pair_report = pair_hit && (32'(found_reg) < 32'(MAX_REPORTED_PAIRS));

    assign wr_entry.ghost = in_item.is_ghost;
    assign wr_entry.x     = in_item.pos_x;
    assign wr_entry.y     = in_item.pos_y;
    assign wr_entry.z     = in_item.pos_z;

    cppd_ram #(
        .WIDTH ($bits(store_entry_t)),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    cppd_dist #(
        .ADDR_W (ADDR_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .entry    (rd_entry),
        .pos_x    (x_reg),
        .pos_y    (y_reg),
        .pos_z    (z_reg),
        .thresh   (thresh_reg),
        .status   (dist_st),
        .out_idx  (dist_idx)
    );

    // sequencer and control state
    always_comb
    begin
        state_next     = state_reg;
        thresh_next    = thresh_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_valid_next  = adv ? issue : rd_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        if (cfg_valid && cfg_ready)
        begin
            thresh_next = cfg_data;
        end

        if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end

        if (pair_hit)
        begin
            found_next = found_reg + 1'b1;
        end

        if (pair_report)
        begin
            out_valid_next              = 1'b1;
            out_item_next.is_pair       = 1'b1;
            out_item_next.earlier_index = IDX_WIDTH'(dist_idx);
            out_item_next.new_index     = IDX_WIDTH'(idx_reg);
            out_item_next.close_count   = '0;
            out_item_next.truncated     = 1'b0;
            out_item_next.set_full      = 1'b0;
            out_item_next.last          = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_item.action == ACT_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        found_next  = '0;
                        rd_ptr_next = '0;
                        if (!is_full)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end && adv)
                begin
                    state_next                  = ST_IDLE;
                    out_valid_next              = 1'b1;
                    out_item_next.is_pair       = 1'b0;
                    out_item_next.earlier_index = '0;
                    out_item_next.new_index     = full_reg ? '0 : IDX_WIDTH'(idx_reg);
                    out_item_next.close_count   = full_reg ? '0 : IDX_WIDTH'(found_reg);
                    out_item_next.truncated     = !full_reg &&
                                                  (32'(found_reg) > 32'(MAX_REPORTED_PAIRS));
                    out_item_next.set_full      = full_reg;
                    out_item_next.last          = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thresh_reg    <= THRESH_RESET;
            count_reg     <= '0;
            found_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thresh_reg    <= thresh_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (in_acc)
        begin
            idx_reg  <= count_reg[ADDR_W-1:0];
            full_reg <= is_full;
            skip_reg <= in_item.is_ghost | is_full;
            x_reg    <= in_item.pos_x;
            y_reg    <= in_item.pos_y;
            z_reg    <= in_item.pos_z;
        end
        if (issue)
        begin
            rd_idx_reg <= rd_ptr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== tb/sv/close_particle_pair_detector_core_tb.sv =====
// ============================================================================
// close_particle_pair_detector_core_tb: self-checking bench for the core
// Sends add and clear beats, predicts every pair and summary beat from a
// shadow copy of the particle set, and checks each output beat in order.
// Covers the reset threshold, coordinate and threshold extremes, ghosts,
// clears, random clustered traffic and a pair report cut at its limit.
// ============================================================================
module close_particle_pair_detector_core_tb;
    import cppd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int IDLE_CYCLES  = 8;   // a clear may still be in flight
    localparam int DRAIN_LIMIT  = 100_000;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 64;
    localparam int TRUNC_ADDS   = MAX_REPORTED_PAIRS + 3;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_item_t                in_item   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_item_t               out_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [THRESH_WIDTH-1:0] cfg_data  = '0;

    close_particle_pair_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow particle set: what the core should hold after each accepted beat
    // ------------------------------------------------------------------------
    bit                      shadow_ghost [MAX_PARTICLES];
    coord_t                  shadow_x     [MAX_PARTICLES];
    coord_t                  shadow_y     [MAX_PARTICLES];
    coord_t                  shadow_z     [MAX_PARTICLES];
    int                      shadow_count  = 0;
    logic [THRESH_WIDTH-1:0] shadow_thresh = THRESH_RESET;

    // pair and summary beats still owed by the core, oldest first
    out_item_t pending_reports [$];

    int error_count = 0;
    int cycle_count = 0;

    // traffic shaping knobs, changed per test phase
    int burst_max  = 8;
    int gap_max    = 3;
    int burst_left = 0;
    int stall_pct  = 0;
    int stall_run  = 0;

    // random clustered traffic: a few centers plus a jitter radius
    coord_t center_x [4];
    coord_t center_y [4];
    coord_t center_z [4];
    int     jitter = 50;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Squared distance strictly below the threshold. A difference of 2^22 or
    // more can never be close under a 44-bit threshold, so it is rejected
    // before squaring.
    function automatic bit is_too_close(coord_t x, coord_t y, coord_t z, int j);
        longint dx;
        longint dy;
        longint dz;
        longint lim;
        dx  = longint'(x) - longint'(shadow_x[j]);
        dy  = longint'(y) - longint'(shadow_y[j]);
        dz  = longint'(z) - longint'(shadow_z[j]);
        dx  = (dx < 0) ? -dx : dx;
        dy  = (dy < 0) ? -dy : dy;
        dz  = (dz < 0) ? -dz : dz;
        lim = longint'(1) << MAG_WIDTH;
        if (dx >= lim || dy >= lim || dz >= lim)
            return 1'b0;
        return (dx * dx + dy * dy + dz * dz) < longint'({20'd0, shadow_thresh});
    endfunction

    // Appends one owed beat at the tail of the queue.
    task automatic queue_beat(input out_item_t beat);
        pending_reports = {pending_reports, beat};
    endtask

    // Updates the shadow set for one accepted beat and queues the beats it
    // must produce: pairs in ascending earlier index, then the summary.
    task automatic predict_item(input in_item_t it);
        out_item_t beat;
        int        found;
        int        idx;
        found = 0;
        if (it.action == ACT_CLEAR) begin
            shadow_count = 0;
        end else if (shadow_count >= MAX_PARTICLES) begin
            // store full: rejected, summary only
            beat          = '0;
            beat.set_full = 1'b1;
            beat.last     = 1'b1;
            queue_beat(beat);
        end else begin
            idx = shadow_count;
            if (!it.is_ghost) begin
                for (int j = 0; j < idx; j++) begin
                    if (!shadow_ghost[j] && is_too_close(it.pos_x, it.pos_y, it.pos_z, j))
                    begin
                        if (found < MAX_REPORTED_PAIRS) begin
                            beat               = '0;
                            beat.is_pair       = 1'b1;
                            beat.earlier_index = IDX_WIDTH'(j);
                            beat.new_index     = IDX_WIDTH'(idx);
                            queue_beat(beat);
                        end
                        found++;
                    end
                end
            end
            shadow_ghost[idx] = it.is_ghost;
            shadow_x[idx]     = it.pos_x;
            shadow_y[idx]     = it.pos_y;
            shadow_z[idx]     = it.pos_z;
            shadow_count      = idx + 1;

            beat             = '0;
            beat.new_index   = IDX_WIDTH'(idx);
            beat.close_count = IDX_WIDTH'(found);
            beat.truncated   = (found > MAX_REPORTED_PAIRS);
            beat.last        = 1'b1;
            queue_beat(beat);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall pattern and beat checker
    // ------------------------------------------------------------------------

    // Stall runs of random length; stall_pct sets how often a run stalls.
    always @(posedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run <= $urandom_range(0, 5);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // A beat moves on an edge with out_valid high and out_stall low; values
    // seen here are the ones from before the edge.
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected output beat: is_pair %0d new_index %0d",
                       out_item.is_pair, out_item.new_index);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("is_pair",       want.is_pair,       out_item.is_pair);
                check_field("earlier_index", want.earlier_index, out_item.earlier_index);
                check_field("new_index",     want.new_index,     out_item.new_index);
                check_field("close_count",   want.close_count,   out_item.close_count);
                check_field("truncated",     want.truncated,     out_item.truncated);
                check_field("set_full",      want.set_full,      out_item.set_full);
                check_field("last",          want.last,          out_item.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Sends one beat. Valid stays high within a burst; a gap of random length
    // opens between bursts when gap_max allows it.
    task automatic send_item(input in_item_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max > 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_item(it);
        burst_left--;
    endtask

    function automatic in_item_t make_item(action_t act, bit ghost, int x, int y, int z);
        in_item_t it;
        it.action   = act;
        it.is_ghost = ghost;
        it.pos_x    = coord_t'(x);
        it.pos_y    = coord_t'(y);
        it.pos_z    = coord_t'(z);
        return it;
    endfunction

    // Drops valid and waits until every owed beat is in, plus a margin for
    // a clear that produces nothing.
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        shadow_thresh = value;
    endtask

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 3))
            0:       return coord_t'(-524288);
            1:       return coord_t'(524287);
            2:       return coord_t'(0);
            default: return coord_t'(-1);
        endcase
    endfunction

    // Mostly clustered adds so that pairs show up, some far-flung noise,
    // ghosts, and the odd clear to keep the set (and the scans) short.
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       c;
        it.action   = ($urandom_range(0, 99) < 4) ? ACT_CLEAR : ACT_ADD;
        it.is_ghost = ($urandom_range(0, 99) < 15);
        pick        = $urandom_range(0, 99);
        if (pick < 15) begin
            it.pos_x = coord_t'($urandom);
            it.pos_y = coord_t'($urandom);
            it.pos_z = coord_t'($urandom);
        end else if (pick < 20) begin
            it.pos_x = extreme_coord();
            it.pos_y = extreme_coord();
            it.pos_z = extreme_coord();
        end else begin
            c        = $urandom_range(0, 3);
            it.pos_x = coord_t'(int'(center_x[c]) + $urandom_range(0, 2 * jitter) - jitter);
            it.pos_y = coord_t'(int'(center_y[c]) + $urandom_range(0, 2 * jitter) - jitter);
            it.pos_z = coord_t'(int'(center_z[c]) + $urandom_range(0, 2 * jitter) - jitter);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Threshold left at its reset value: distances on either side of it.
    task automatic test_reset_threshold();
        burst_max = 4;
        gap_max   = 2;
        stall_pct = 30;
        send_item(make_item(ACT_ADD, 1'b0, 0, 0, 0));
        send_item(make_item(ACT_ADD, 1'b0, 100, 0, 0));     // 10000, close
        send_item(make_item(ACT_ADD, 1'b0, 102, 0, 0));     // 10404, close
        send_item(make_item(ACT_ADD, 1'b0, 103, 0, 0));     // 10609, not to idx 0
        send_item(make_item(ACT_ADD, 1'b1, 0, 0, 0));       // ghost on top of idx 0
        send_item(make_item(ACT_ADD, 1'b0, 0, 0, 1));
        send_item(make_item(ACT_ADD, 1'b0, -60, -60, -60)); // 10800 from origin
    endtask

    // Coordinate corners, then the threshold at its maximum, zero and one.
    task automatic test_extremes();
        burst_max = 2;
        gap_max   = 0;
        stall_pct = 0;
        send_item(make_item(ACT_ADD, 1'b0, 524287, 524287, 524287));
        send_item(make_item(ACT_ADD, 1'b0, -524288, -524288, -524288));
        send_item(make_item(ACT_ADD, 1'b0, 524287, -524288, 0));
        write_threshold({THRESH_WIDTH{1'b1}});  // every non-ghost is close
        send_item(make_item(ACT_ADD, 1'b0, 0, 0, 0));
        send_item(make_item(ACT_ADD, 1'b0, -524288, -524288, -524288));
        write_threshold('0);                   // nothing is close, not even d = 0
        send_item(make_item(ACT_ADD, 1'b0, 0, 0, 0));
        write_threshold(THRESH_WIDTH'(1));     // identical points only
        send_item(make_item(ACT_ADD, 1'b0, 0, 0, 0));
        send_item(make_item(ACT_ADD, 1'b1, 524287, 524287, 524287));
    endtask

    // Clears (back to back too) restart indexing; ghosts are never compared.
    task automatic test_clear_and_ghost();
        burst_max = 3;
        gap_max   = 1;
        stall_pct = 50;
        send_item(make_item(ACT_CLEAR, 1'b1, -1, -1, -1));
        send_item(make_item(ACT_ADD, 1'b0, 5, 5, 5));
        send_item(make_item(ACT_CLEAR, 1'b0, 0, 0, 0));
        send_item(make_item(ACT_CLEAR, 1'b0, 524287, -524288, 7));
        send_item(make_item(ACT_ADD, 1'b1, -1, -1, -1));
        send_item(make_item(ACT_ADD, 1'b0, -1, -1, -1));
        send_item(make_item(ACT_ADD, 1'b0, -1, -1, -1));
    endtask

    task automatic random_phase(input int n, input logic [THRESH_WIDTH-1:0] thresh,
                                input int stall, input int burst, input int gap);
        write_threshold(thresh);
        stall_pct = stall;
        burst_max = burst;
        gap_max   = gap;
        jitter    = $urandom_range(0, 200);
        for (int c = 0; c < 4; c++) begin
            center_x[c] = coord_t'($urandom);
            center_y[c] = coord_t'($urandom);
            center_z[c] = coord_t'($urandom);
        end
        for (int i = 0; i < n; i++)
            send_item(random_item());
    endtask

    task automatic test_random_traffic();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        random_phase(PHASE_ITEMS, THRESH_RESET, 0, 16, 0);       // no idling at all
        random_phase(PHASE_ITEMS, THRESH_WIDTH'($urandom_range(0, 1 << 24)), 30, 6, 3);
        random_phase(PHASE_ITEMS, wide[THRESH_WIDTH-1:0], 20, 4, 2);
        random_phase(PHASE_ITEMS, THRESH_WIDTH'(1), 70, 3, 6);
    endtask

    // A tight cluster of non-ghosts: every one is close to all earlier ones,
    // so the last few see more than 63 close particles and their report is
    // cut at 63 pairs with truncated set.
    task automatic test_pair_truncation();
        write_threshold(THRESH_RESET);
        send_item(make_item(ACT_CLEAR, 1'b0, 0, 0, 0));
        stall_pct = 20;
        burst_max = 16;
        gap_max   = 2;
        for (int i = 0; i < TRUNC_ADDS; i++) begin
            send_item(make_item(ACT_ADD, 1'b0,
                                1000 + $urandom_range(0, 40) - 20,
                                -2000 + $urandom_range(0, 40) - 20,
                                3000 + $urandom_range(0, 40) - 20));
        end
        send_item(make_item(ACT_ADD, 1'b1, 1000, -2000, 3000));
        send_item(make_item(ACT_CLEAR, 1'b0, 0, 0, 0));
        send_item(make_item(ACT_ADD, 1'b0, 1000, -2000, 3000));
    endtask

    // ------------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------------
    initial begin
        int drain;
        drain = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_threshold();
        test_extremes();
        test_clear_and_ghost();
        test_random_traffic();
        test_pair_truncation();

        in_valid <= 1'b0;
        while (pending_reports.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (IDLE_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0) begin
            $error("%0d expected beats never arrived", pending_reports.size());
            error_count++;
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cppd_pkg.sv
hw/rtl/cppd_ram.sv
hw/rtl/cppd_dist.sv
hw/rtl/close_particle_pair_detector_core.sv
tb/sv/close_particle_pair_detector_core_tb.sv
